/* design/envelope_segment_time_sense_assert.svh */
// ----------------------------------------------------------------------------
// Envelope segment time sense - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_SEGMENT_TIME_SENSE_ASSERT_SVH
`define ENVELOPE_SEGMENT_TIME_SENSE_ASSERT_SVH

// same-cycle implication
`define EST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("est assertion failed");

// next-cycle implication
`define EST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("est assertion failed");

`endif

/* design/est_pkg.sv */
// ----------------------------------------------------------------------------
// est_pkg
// Types, constants and helpers shared by the segment time sense block.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int DIV_STEPS = 19;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [18:0] LONGEST_MS = 19'd524280;
  localparam logic [15:0] MS_MAX     = 16'hFFFF;
  localparam logic [6:0]  VEL_CENTER = 7'd64;
  localparam logic [6:0]  KEY_CENTER = 7'd60;
  localparam logic [6:0]  KEY_OCTAVE = 7'd12;
  localparam logic [3:0]  OCT_GROUP  = 4'd12;
  localparam logic [9:0]  UNITY      = 10'd256;

  localparam logic [2:0] SEG_T1 = 3'd0;
  localparam logic [2:0] SEG_T2 = 3'd1;
  localparam logic [2:0] SEG_T3 = 3'd2;
  localparam logic [2:0] SEG_T4 = 3'd3;

  localparam logic        RST_ENABLE  = 1'b0;
  localparam logic [12:0] RST_DEPTH   = 13'd0;
  localparam logic [5:0]  RST_KF      = 6'd0;
  localparam logic [6:0]  RST_KEY     = 7'd60;
  localparam logic [6:0]  RST_VEL     = 7'd64;
  localparam logic        RST_REL_ON  = 1'b0;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_T1_DEPTH    = 3'd1,
    REG_T4_DEPTH    = 3'd2,
    REG_KF_DEPTH    = 3'd3,
    REG_NOTE_KEY    = 3'd4,
    REG_NOTE_ON_VEL = 3'd5,
    REG_REL_VEL     = 3'd6,
    REG_REL_USES_ON = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic              enable_time_sense;
    logic signed [12:0] t1_vel_depth;
    logic signed [12:0] t4_vel_depth;
    logic signed [5:0]  key_follow_depth;
    logic [6:0]        note_key;
    logic [6:0]        note_on_velocity;
    logic [6:0]        release_velocity;
    logic              release_uses_note_on;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_VEL_MUL,
    ST_VEL_ADD,
    ST_KF_INIT,
    ST_GAIN,
    ST_UP_MUL,
    ST_UP_ADD,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_VEL_MUL,
    OP_VEL_ADD,
    OP_KF_INIT,
    OP_GAIN,
    OP_UP_MUL,
    OP_UP_ADD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic vel_seg;
    logic t4_seg;
    logic kf_skip;
    logic kf_up;
    logic oct_last;
    logic up_sat;
  } stat_t;

  // whole octaves in a key distance of 0..127
  function automatic logic [3:0] oct_count(input logic [6:0] an);
    logic [3:0] c;
    c = 4'd0;
    if (an >= 7'd12)  c = 4'd1;
    if (an >= 7'd24)  c = 4'd2;
    if (an >= 7'd36)  c = 4'd3;
    if (an >= 7'd48)  c = 4'd4;
    if (an >= 7'd60)  c = 4'd5;
    if (an >= 7'd72)  c = 4'd6;
    if (an >= 7'd84)  c = 4'd7;
    if (an >= 7'd96)  c = 4'd8;
    if (an >= 7'd108) c = 4'd9;
    if (an >= 7'd120) c = 4'd10;
    return c;
  endfunction

endpackage

/* design/est_regs.sv */
// ----------------------------------------------------------------------------
// est_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module est_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [est_pkg::PADDR_W-1:0] paddr,
  input  logic [est_pkg::PDATA_W-1:0] pwdata,
  output logic [est_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output est_pkg::cfg_t               cfg
);

  logic        enable_r;
  logic [12:0] t1_depth_r;
  logic [12:0] t4_depth_r;
  logic [5:0]  kf_r;
  logic [6:0]  key_r;
  logic [6:0]  von_r;
  logic [6:0]  vrel_r;
  logic        rel_on_r;
  logic        wr_en;
  est_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = est_pkg::reg_idx_t'(paddr[est_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= est_pkg::RST_ENABLE;
      t1_depth_r <= est_pkg::RST_DEPTH;
      t4_depth_r <= est_pkg::RST_DEPTH;
      kf_r       <= est_pkg::RST_KF;
      key_r      <= est_pkg::RST_KEY;
      von_r      <= est_pkg::RST_VEL;
      vrel_r     <= est_pkg::RST_VEL;
      rel_on_r   <= est_pkg::RST_REL_ON;
    end else if (wr_en) begin
      case (idx)
        est_pkg::REG_ENABLE:      enable_r   <= pwdata[0];
        est_pkg::REG_T1_DEPTH:    t1_depth_r <= pwdata[12:0];
        est_pkg::REG_T4_DEPTH:    t4_depth_r <= pwdata[12:0];
        est_pkg::REG_KF_DEPTH:    kf_r       <= pwdata[5:0];
        est_pkg::REG_NOTE_KEY:    key_r      <= pwdata[6:0];
        est_pkg::REG_NOTE_ON_VEL: von_r      <= pwdata[6:0];
        est_pkg::REG_REL_VEL:     vrel_r     <= pwdata[6:0];
        est_pkg::REG_REL_USES_ON: rel_on_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      est_pkg::REG_ENABLE:      prdata = {31'd0, enable_r};
      est_pkg::REG_T1_DEPTH:    prdata = {19'd0, t1_depth_r};
      est_pkg::REG_T4_DEPTH:    prdata = {19'd0, t4_depth_r};
      est_pkg::REG_KF_DEPTH:    prdata = {26'd0, kf_r};
      est_pkg::REG_NOTE_KEY:    prdata = {25'd0, key_r};
      est_pkg::REG_NOTE_ON_VEL: prdata = {25'd0, von_r};
      est_pkg::REG_REL_VEL:     prdata = {25'd0, vrel_r};
      est_pkg::REG_REL_USES_ON: prdata = {31'd0, rel_on_r};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    cfg.enable_time_sense    = enable_r;
    cfg.t1_vel_depth         = t1_depth_r;
    cfg.t4_vel_depth         = t4_depth_r;
    cfg.key_follow_depth     = kf_r;
    cfg.note_key             = key_r;
    cfg.note_on_velocity     = von_r;
    cfg.release_velocity     = vrel_r;
    cfg.release_uses_note_on = rel_on_r;
  end

endmodule

/* design/est_dp.sv */
// ----------------------------------------------------------------------------
// est_dp
// Datapath: velocity term, key follow multiply and shift-subtract divider.
// ----------------------------------------------------------------------------
module est_dp (
  input  logic           clk,
  input  est_pkg::cfg_t  cfg,
  input  est_pkg::cmd_t  cmd,
  input  logic [15:0]    in_segment_ms,
  input  logic [2:0]     in_segment,
  output est_pkg::stat_t stat,
  output logic [18:0]    out_adjusted_ms
);

  logic [18:0] v_r;
  logic [2:0]  seg_r;
  logic        up_r;
  logic [3:0]  octs_r;
  logic [3:0]  g_r;
  logic [8:0]  mg_r;
  logic [27:0] prod_r;
  logic [9:0]  rem_r;
  logic [18:0] q_r;
  logic [18:0] out_r;

  logic [6:0]  vel_sel;
  logic [12:0] dep_sel;
  logic [12:0] ad;
  logic        vel_ge;
  logic [6:0]  as;
  logic        vel_up;
  logic [10:0] vel_t;
  logic [16:0] vel_sum;
  logic [18:0] vel_res;

  logic [5:0]  kk;
  logic        key_ge;
  logic [6:0]  an;
  logic [3:0]  octs0;
  logic [3:0]  g0;
  logic        kf_up;

  logic [20:0] up_sum;
  logic        up_sat;

  logic [9:0]  dvs;
  logic [10:0] trial;
  logic        ge;
  logic [9:0]  rem_nxt;

  always_comb begin
    vel_sel = (seg_r == est_pkg::SEG_T1 || cfg.release_uses_note_on) ?
              cfg.note_on_velocity : cfg.release_velocity;
    dep_sel = (seg_r == est_pkg::SEG_T1) ? cfg.t1_vel_depth : cfg.t4_vel_depth;
    ad      = dep_sel[12] ? 13'(-dep_sel) : dep_sel;
    vel_ge  = vel_sel >= est_pkg::VEL_CENTER;
    as      = vel_ge ? 7'(vel_sel - est_pkg::VEL_CENTER)
                     : 7'(est_pkg::VEL_CENTER - vel_sel);
    vel_up  = (!dep_sel[12]) == vel_ge;
    vel_t   = prod_r[18:8];
    vel_sum = 17'(v_r[15:0]) + 17'(vel_t);
    if (vel_up) begin
      vel_res = (vel_sum > 17'(est_pkg::MS_MAX)) ? est_pkg::LONGEST_MS : 19'(vel_sum);
    end else begin
      vel_res = (19'(vel_t) >= v_r) ? 19'd0 : 19'(v_r - 19'(vel_t));
    end
  end

  always_comb begin
    kk     = cfg.key_follow_depth[5] ? 6'(-cfg.key_follow_depth) : cfg.key_follow_depth;
    key_ge = cfg.note_key >= est_pkg::KEY_CENTER;
    an     = key_ge ? 7'(cfg.note_key - est_pkg::KEY_CENTER)
                    : 7'(est_pkg::KEY_CENTER - cfg.note_key);
    octs0  = est_pkg::oct_count(an);
    g0     = 4'(an - 7'(7'(octs0) * est_pkg::KEY_OCTAVE));
    kf_up  = (!cfg.key_follow_depth[5] && cfg.key_follow_depth != 6'd0) == key_ge;
  end

  always_comb begin
    up_sum  = 21'(v_r) + 21'(prod_r[27:8]);
    up_sat  = up_sum > 21'(est_pkg::MS_MAX);
    dvs     = est_pkg::UNITY + 10'(mg_r);
    trial   = {rem_r, q_r[18]};
    ge      = trial >= {1'b0, dvs};
    rem_nxt = ge ? 10'(trial - {1'b0, dvs}) : trial[9:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      est_pkg::OP_LOAD: begin
        v_r   <= {3'd0, in_segment_ms};
        seg_r <= in_segment;
      end
      est_pkg::OP_VEL_MUL: prod_r <= 28'(ad) * 28'(as);
      est_pkg::OP_VEL_ADD: v_r    <= vel_res;
      est_pkg::OP_KF_INIT: begin
        up_r   <= kf_up;
        octs_r <= octs0;
        g_r    <= g0;
      end
      est_pkg::OP_GAIN:   mg_r   <= 9'(kk) * 9'(g_r);
      est_pkg::OP_UP_MUL: prod_r <= 28'(mg_r) * 28'(v_r);
      est_pkg::OP_UP_ADD: begin
        v_r <= up_sat ? est_pkg::LONGEST_MS : 19'(up_sum);
        if (octs_r != 4'd0) begin
          octs_r <= octs_r - 4'd1;
          g_r    <= est_pkg::OCT_GROUP;
        end
      end
      est_pkg::OP_DIV_INIT: begin
        rem_r <= {2'd0, v_r[18:11]};
        q_r   <= {v_r[10:0], 8'd0};
      end
      est_pkg::OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[17:0], ge};
      end
      est_pkg::OP_DIV_END: begin
        v_r <= q_r;
        if (octs_r != 4'd0) begin
          octs_r <= octs_r - 4'd1;
          g_r    <= est_pkg::OCT_GROUP;
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_r <= v_r;
    end
  end

  always_comb begin
    stat.bypass   = !cfg.enable_time_sense || v_r == 19'd0 || seg_r[2];
    stat.vel_seg  = seg_r == est_pkg::SEG_T1 || seg_r == est_pkg::SEG_T4;
    stat.t4_seg   = seg_r == est_pkg::SEG_T4;
    stat.kf_skip  = cfg.key_follow_depth == 6'd0 || v_r == 19'd0;
    stat.kf_up    = up_r;
    stat.oct_last = octs_r == 4'd0;
    stat.up_sat   = up_sat;
  end

  assign out_adjusted_ms = out_r;

endmodule

/* design/est_ctrl.sv */
// ----------------------------------------------------------------------------
// est_ctrl
// Sequencer for one segment time: steps the datapath, owns the result beat.
// ----------------------------------------------------------------------------
`include "envelope_segment_time_sense_assert.svh"

module est_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  est_pkg::stat_t stat,
  output est_pkg::cmd_t  cmd
);

  est_pkg::state_t state_r, state_nxt;
  logic [est_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= est_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == est_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.op       = est_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      est_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = est_pkg::OP_LOAD;
          state_nxt = est_pkg::ST_DISPATCH;
        end
      end
      est_pkg::ST_DISPATCH: begin
        if (stat.bypass) state_nxt = est_pkg::ST_FINISH;
        else if (stat.vel_seg) state_nxt = est_pkg::ST_VEL_MUL;
        else state_nxt = est_pkg::ST_KF_INIT;
      end
      est_pkg::ST_VEL_MUL: begin
        cmd.op    = est_pkg::OP_VEL_MUL;
        state_nxt = est_pkg::ST_VEL_ADD;
      end
      est_pkg::ST_VEL_ADD: begin
        cmd.op    = est_pkg::OP_VEL_ADD;
        state_nxt = stat.t4_seg ? est_pkg::ST_KF_INIT : est_pkg::ST_FINISH;
      end
      est_pkg::ST_KF_INIT: begin
        if (stat.kf_skip) begin
          state_nxt = est_pkg::ST_FINISH;
        end else begin
          cmd.op    = est_pkg::OP_KF_INIT;
          state_nxt = est_pkg::ST_GAIN;
        end
      end
      est_pkg::ST_GAIN: begin
        cmd.op    = est_pkg::OP_GAIN;
        state_nxt = stat.kf_up ? est_pkg::ST_UP_MUL : est_pkg::ST_DIV_INIT;
      end
      est_pkg::ST_UP_MUL: begin
        cmd.op    = est_pkg::OP_UP_MUL;
        state_nxt = est_pkg::ST_UP_ADD;
      end
      est_pkg::ST_UP_ADD: begin
        cmd.op    = est_pkg::OP_UP_ADD;
        state_nxt = (stat.up_sat || stat.oct_last) ? est_pkg::ST_FINISH : est_pkg::ST_GAIN;
      end
      est_pkg::ST_DIV_INIT: begin
        cmd.op    = est_pkg::OP_DIV_INIT;
        cnt_nxt   = est_pkg::CNT_W'(est_pkg::DIV_STEPS - 1);
        state_nxt = est_pkg::ST_DIV_STEP;
      end
      est_pkg::ST_DIV_STEP: begin
        cmd.op = est_pkg::OP_DIV_STEP;
        if (cnt_r == '0) state_nxt = est_pkg::ST_DIV_END;
        else cnt_nxt = cnt_r - est_pkg::CNT_W'(1);
      end
      est_pkg::ST_DIV_END: begin
        cmd.op    = est_pkg::OP_DIV_END;
        state_nxt = stat.oct_last ? est_pkg::ST_FINISH : est_pkg::ST_GAIN;
      end
      est_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = est_pkg::ST_IDLE;
        end
      end
      default: state_nxt = est_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  `EST_ASSERT_IMP(a_load_free, cmd.out_load, !out_valid_r || out_ready)
  `EST_ASSERT_IMP(a_load_beat, cmd.op == est_pkg::OP_LOAD, in_valid && in_ready)
  `EST_ASSERT_NXT(a_div_done,
                  state_r == est_pkg::ST_DIV_STEP && cnt_r == '0,
                  state_r == est_pkg::ST_DIV_END)

endmodule

/* design/envelope_segment_time_sense.sv */
// ----------------------------------------------------------------------------
// envelope_segment_time_sense
// Adjusts an envelope segment time by velocity and key follow.
// ----------------------------------------------------------------------------
// One segment time is worked on at a time. A passed-through time goes from
// DISPATCH straight to FINISH; T1 adds a velocity multiply and add. Key follow
// adds a setup step (KF_INIT), then per semitone group a gain, multiply and add
// going up (ending early once the time saturates) or a gain and a divide going
// down, where the divider retires one quotient bit a cycle over 19 bits. With
// up to six groups the longest item is T4 with key follow down; FINISH also
// waits while the previous result still waits for out_ready. The result sits
// in an output register, so the next beat is taken while it waits.
module envelope_segment_time_sense (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_segment_ms,
  input  logic [2:0]                  in_segment,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [18:0]                 out_adjusted_ms,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [est_pkg::PADDR_W-1:0] paddr,
  input  logic [est_pkg::PDATA_W-1:0] pwdata,
  output logic [est_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  est_pkg::cfg_t  cfg;
  est_pkg::cmd_t  cmd;
  est_pkg::stat_t stat;

  est_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  est_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  est_dp u_dp (
    .clk             (clk),
    .cfg             (cfg),
    .cmd             (cmd),
    .in_segment_ms   (in_segment_ms),
    .in_segment      (in_segment),
    .stat            (stat),
    .out_adjusted_ms (out_adjusted_ms)
  );

endmodule

/* test/envelope_segment_time_sense_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_segment_time_sense_tb
// Self-checking bench for the segment time sense block. Register settings go
// in over the APB port while the block is idle, segment beats go in with
// random gaps or back to back, and each result beat is checked against a time
// predicted from a local copy of the registers. Directed cases cover the
// saturation, floor, key follow and passthrough corners; random phases cover the rest.
// ----------------------------------------------------------------------------
module envelope_segment_time_sense_tb;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          SETTLE      = 8;
  localparam logic [2:0]  SEG_OTHER   = 3'd4;
  localparam logic [2:0]  SEG_LAST    = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [15:0]                   in_segment_ms = '0;
  logic [2:0]                    in_segment = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [18:0]                   out_adjusted_ms;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [est_pkg::PADDR_W-1:0]   paddr = '0;
  logic [est_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [est_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  // register mirror
  logic                 ts_enable = est_pkg::RST_ENABLE;
  logic signed [12:0]   t1_depth = est_pkg::RST_DEPTH;
  logic signed [12:0]   t4_depth = est_pkg::RST_DEPTH;
  logic signed [5:0]    kf_depth = est_pkg::RST_KF;
  logic [6:0]           key_num = est_pkg::RST_KEY;
  logic [6:0]           vel_on = est_pkg::RST_VEL;
  logic [6:0]           vel_rel = est_pkg::RST_VEL;
  logic                 rel_on = est_pkg::RST_REL_ON;

  logic [18:0]          expected_ms_q[$];
  logic [18:0]          exp_ms;
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   ready_hold = 0;
  bit                   no_gaps = 1'b0;

  envelope_segment_time_sense DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_segment_ms   (in_segment_ms),
    .in_segment      (in_segment),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_adjusted_ms (out_adjusted_ms),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("envelope_segment_time_sense verification failed");
      $finish;
    end
  end

  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  // additive velocity term, floored at 0 and saturating above 16 bits
  function automatic int unsigned vel_adjust(int unsigned ms, int depth, int unsigned vel);
    int          offs;
    int unsigned mag_d;
    int unsigned mag_s;
    int unsigned t;
    offs  = int'(vel) - int'(est_pkg::VEL_CENTER);
    mag_d = (depth < 0) ? -depth : depth;
    mag_s = (offs < 0) ? -offs : offs;
    t     = (mag_d * mag_s) >> 8;
    if ((depth >= 0) == (offs >= 0)) begin
      if (ms + t > est_pkg::MS_MAX) return est_pkg::LONGEST_MS;
      return ms + t;
    end
    return (t >= ms) ? 0 : ms - t;
  endfunction

  // compounded key follow: partial group first, then one per whole octave
  function automatic int unsigned key_follow_adjust(int unsigned ms, int k, int unsigned key);
    int                key_dist;
    bit                up;
    longint unsigned   kk;
    longint unsigned   v;
    int unsigned       adist;
    int unsigned       octs;
    int unsigned       grp;
    if (k == 0 || ms == 0) return ms;
    key_dist = int'(key) - int'(est_pkg::KEY_CENTER);
    up       = (k > 0) == (key_dist >= 0);
    kk       = (k < 0) ? -k : k;
    adist    = (key_dist < 0) ? -key_dist : key_dist;
    octs     = adist / est_pkg::KEY_OCTAVE;
    grp      = adist % est_pkg::KEY_OCTAVE;
    v        = ms;
    for (int unsigned i = 0; i <= octs; i++) begin
      if (up) begin
        v += (kk * grp * v) >> 8;
        if (v > est_pkg::MS_MAX) return est_pkg::LONGEST_MS;
      end else begin
        v = (v << 8) / (est_pkg::UNITY + kk * grp);
      end
      grp = est_pkg::OCT_GROUP;
    end
    return 32'(v);
  endfunction

  function automatic logic [18:0] predict_adjusted(logic [15:0] ms, logic [2:0] seg);
    int unsigned r;
    r = ms;
    if (ts_enable && ms != 0) begin
      case (seg)
        est_pkg::SEG_T1: r = vel_adjust(ms, t1_depth, vel_on);
        est_pkg::SEG_T2, est_pkg::SEG_T3: r = key_follow_adjust(ms, kf_depth, key_num);
        est_pkg::SEG_T4: begin
          r = vel_adjust(ms, t4_depth, rel_on ? vel_on : vel_rel);
          r = key_follow_adjust(r, kf_depth, key_num);
        end
        default: r = ms;
      endcase
    end
    return r[18:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ms_q.size() == 0) begin
          $error("unexpected result beat: adjusted_ms %0d", out_adjusted_ms);
          mismatch_count++;
        end else begin
          exp_ms = expected_ms_q.pop_front();
          if (out_adjusted_ms !== exp_ms) begin
            $error("adjusted_ms: expected %0d, actual %0d", exp_ms, out_adjusted_ms);
            mismatch_count++;
          end
        end
        ready_hold = draw_wait();
      end
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_segment(input logic [15:0] ms, input logic [2:0] seg);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_segment_ms <= ms;
    in_segment    <= seg;
    do @(posedge clk); while (!in_ready);
    expected_ms_q.push_back(predict_adjusted(ms, seg));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_ms_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input est_pkg::reg_idx_t idx, input logic [31:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      est_pkg::REG_ENABLE:      ts_enable = value[0];
      est_pkg::REG_T1_DEPTH:    t1_depth  = value[12:0];
      est_pkg::REG_T4_DEPTH:    t4_depth  = value[12:0];
      est_pkg::REG_KF_DEPTH:    kf_depth  = value[5:0];
      est_pkg::REG_NOTE_KEY:    key_num   = value[6:0];
      est_pkg::REG_NOTE_ON_VEL: vel_on    = value[6:0];
      est_pkg::REG_REL_VEL:     vel_rel   = value[6:0];
      est_pkg::REG_REL_USES_ON: rel_on    = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_segment(16'hFFFF, est_pkg::SEG_T1);
    send_segment(16'hFFFF, est_pkg::SEG_T2);
    send_segment(16'h0001, est_pkg::SEG_T3);
    send_segment(16'h8000, est_pkg::SEG_T4);
    send_segment(16'h0000, SEG_OTHER);
    send_segment(16'h1234, SEG_LAST);
    write_reg(est_pkg::REG_ENABLE, 32'd1);
    send_segment(16'hFFFF, est_pkg::SEG_T4);
    send_segment(16'h0000, est_pkg::SEG_T1);
  endtask

  task automatic test_velocity_t1();
    write_reg(est_pkg::REG_T1_DEPTH, 32'd4095);
    write_reg(est_pkg::REG_NOTE_ON_VEL, 32'd127);
    send_segment(16'hFFFF, est_pkg::SEG_T1);
    send_segment(16'h0001, est_pkg::SEG_T1);
    write_reg(est_pkg::REG_T1_DEPTH, -32'sd4096);
    send_segment(16'd100, est_pkg::SEG_T1);
    write_reg(est_pkg::REG_NOTE_ON_VEL, 32'd0);
    send_segment(16'd100, est_pkg::SEG_T1);
  endtask

  task automatic test_key_follow();
    write_reg(est_pkg::REG_KF_DEPTH, 32'd31);
    write_reg(est_pkg::REG_NOTE_KEY, 32'd127);
    send_segment(16'd1000, est_pkg::SEG_T2);
    write_reg(est_pkg::REG_KF_DEPTH, -32'sd32);
    send_segment(16'hFFFF, est_pkg::SEG_T3);
    write_reg(est_pkg::REG_KF_DEPTH, 32'd21);
    write_reg(est_pkg::REG_NOTE_KEY, 32'd0);
    send_segment(16'hFFFF, est_pkg::SEG_T2);
    write_reg(est_pkg::REG_NOTE_KEY, 32'd60);
    send_segment(16'd777, est_pkg::SEG_T3);
  endtask

  task automatic test_release_t4();
    write_reg(est_pkg::REG_T4_DEPTH, 32'd4095);
    write_reg(est_pkg::REG_REL_VEL, 32'd127);
    write_reg(est_pkg::REG_KF_DEPTH, -32'sd32);
    write_reg(est_pkg::REG_NOTE_KEY, 32'd127);
    // saturated release time, then divided by key follow
    send_segment(16'hFFFF, est_pkg::SEG_T4);
    write_reg(est_pkg::REG_REL_USES_ON, 32'd1);
    send_segment(16'd500, est_pkg::SEG_T4);
    send_segment(16'h0000, est_pkg::SEG_T4);
    write_reg(est_pkg::REG_ENABLE, 32'd0);
    send_segment(16'hFFFF, est_pkg::SEG_T4);
  endtask

  function automatic logic [31:0] pick_depth();
    case ($urandom_range(0, 7))
      0: return -32'sd4096;
      1: return 32'd4095;
      2: return -32'sd4000;
      3: return 32'd4000;
      4: return 32'd0;
      default: return $urandom_range(0, 8000) - 4000;
    endcase
  endfunction

  function automatic logic [31:0] pick_kf();
    case ($urandom_range(0, 7))
      0: return -32'sd32;
      1: return 32'd31;
      2: return -32'sd21;
      3: return 32'd21;
      4: return 32'd0;
      default: return $urandom_range(0, 42) - 21;
    endcase
  endfunction

  function automatic logic [31:0] pick_7bit(input logic [6:0] center);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd127;
      2: return 32'(center);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  task automatic send_random_segment();
    logic [15:0] ms;
    int          pick;
    case ($urandom_range(0, 7))
      0: ms = 16'h0000;
      1: ms = 16'hFFFF;
      2: ms = 16'($urandom_range(1, 255));
      3: ms = 16'($urandom_range(0, 4095));
      default: ms = 16'($urandom_range(0, 65535));
    endcase
    pick = $urandom_range(0, 11);
    send_segment(ms, (pick < 8) ? 3'(pick % 4) : 3'(pick - 4));
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(est_pkg::REG_ENABLE, 32'($urandom_range(0, 5) != 0));
      write_reg(est_pkg::REG_T1_DEPTH, pick_depth());
      write_reg(est_pkg::REG_T4_DEPTH, pick_depth());
      write_reg(est_pkg::REG_KF_DEPTH, pick_kf());
      write_reg(est_pkg::REG_NOTE_KEY, pick_7bit(est_pkg::KEY_CENTER));
      write_reg(est_pkg::REG_NOTE_ON_VEL, pick_7bit(est_pkg::VEL_CENTER));
      write_reg(est_pkg::REG_REL_VEL, pick_7bit(est_pkg::VEL_CENTER));
      write_reg(est_pkg::REG_REL_USES_ON, $urandom_range(0, 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (per_phase) send_random_segment();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_back_to_back();
    write_reg(est_pkg::REG_ENABLE, 32'd1);
    write_reg(est_pkg::REG_KF_DEPTH, -32'sd21);
    write_reg(est_pkg::REG_NOTE_KEY, 32'd0);
    no_gaps = 1'b1;
    repeat (40) send_random_segment();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_velocity_t1();
    test_key_follow();
    test_release_t4();
    test_random_settings(14, 40);
    test_back_to_back();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("envelope_segment_time_sense verification clean");
    end else begin
      $display("envelope_segment_time_sense verification failed");
    end
    $finish;
  end

endmodule
